// ----- rtl/prbd_pkg.sv -----
`timescale 1ns / 1ps
package prbd_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);

    // decoder mode of the front part
    typedef enum logic [1:0] {
        MODE_CMD    = 2'd0,
        MODE_LIT    = 2'd1,
        MODE_PLAYER = 2'd2,
        MODE_FILL   = 2'd3
    } decode_mode_t;

    // run kind in the top two bits of a command byte
    typedef enum logic [1:0] {
        RUN_SKIP   = 2'b00,
        RUN_LIT    = 2'b01,
        RUN_PLAYER = 2'b10,
        RUN_FILL   = 2'b11
    } run_kind_t;

    // pixel kinds as they leave the block
    typedef enum logic [1:0] {
        PIX_TRANSP = 2'd0,
        PIX_COLOR  = 2'd1,
        PIX_PLAYER = 2'd2
    } pixel_kind_t;

    localparam logic [7:0] PlayerOffset = 8'd128;

    // one run handed from front to back
    typedef struct packed {
        logic        restart;  // clear column and row before this run
        pixel_kind_t kind;
        logic [7:0]  color;
        logic [7:0]  shade;
        logic [5:0]  count;    // may be zero when only restart is carried
    } run_cmd_t;

endpackage

// ----- rtl/prbd_front.sv -----
`timescale 1ns / 1ps
module prbd_front
    import prbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] image_width,
    input  logic        byte_valid,
    input  logic [7:0]  data_byte,
    input  logic        start_image,
    input  logic        q_full,
    output logic        byte_ready,
    output logic        push,
    output run_cmd_t    push_cmd
);

    decode_mode_t mode_reg, mode_next;
    logic [5:0]   pend_reg, pend_next;
    logic [15:0]  col_reg, col_next;
    logic         fix_reg, fix_next;

    decode_mode_t mode_eff;
    logic [5:0]   pend_eff;
    logic [15:0]  col_eff;
    logic [16:0]  room;
    logic [5:0]   cnt_cut;
    logic [16:0]  col_sum;
    logic [16:0]  col_wrap;
    logic         take;

    // no bytes while the column is being folded back into the row
    assign byte_ready = !q_full && !fix_reg;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        mode_eff = start_image ? MODE_CMD : mode_reg;
        pend_eff = start_image ? 6'd0 : pend_reg;
        col_eff  = start_image ? 16'd0 : col_reg;

        // room left in the row; one when the column is already past the width
        if (image_width > col_eff)
            room = {1'b0, image_width} - {1'b0, col_eff};
        else
            room = 17'd1;
        if ({11'd0, data_byte[5:0]} > room)
            cnt_cut = room[5:0];
        else
            cnt_cut = data_byte[5:0];
    end

    // next mode and pending count
    always_comb
    begin
        mode_next = mode_eff;
        pend_next = pend_eff;

        unique case (mode_eff)
            MODE_CMD:
            begin
                unique case (data_byte[7:6])
                    RUN_SKIP:
                    begin
                        mode_next = MODE_CMD;
                    end
                    RUN_LIT:
                    begin
                        pend_next = cnt_cut;
                        mode_next = (cnt_cut != 6'd0) ? MODE_LIT : MODE_CMD;
                    end
                    RUN_PLAYER:
                    begin
                        pend_next = cnt_cut;
                        mode_next = MODE_PLAYER;
                    end
                    default:
                    begin
                        pend_next = cnt_cut;
                        mode_next = MODE_FILL;
                    end
                endcase
            end
            MODE_LIT:
            begin
                pend_next = pend_eff - 6'd1;
                if (pend_next == 6'd0)
                    mode_next = MODE_CMD;
            end
            default:
            begin
                pend_next = 6'd0;
                mode_next = MODE_CMD;
            end
        endcase
    end

    // run handed to the queue
    always_comb
    begin
        push_cmd.restart = start_image;
        push_cmd.kind    = PIX_TRANSP;
        push_cmd.color   = 8'd0;
        push_cmd.shade   = 8'd0;
        push_cmd.count   = 6'd0;

        unique case (mode_eff)
            MODE_CMD:
            begin
                if (data_byte[7:6] == RUN_SKIP)
                    push_cmd.count = cnt_cut;
            end
            MODE_LIT:
            begin
                push_cmd.kind  = PIX_COLOR;
                push_cmd.color = data_byte;
                push_cmd.count = 6'd1;
            end
            MODE_PLAYER:
            begin
                push_cmd.kind  = PIX_PLAYER;
                push_cmd.color = data_byte + PlayerOffset;
                push_cmd.shade = data_byte;
                push_cmd.count = pend_eff;
            end
            default:
            begin
                push_cmd.kind  = PIX_COLOR;
                push_cmd.color = data_byte;
                push_cmd.count = pend_eff;
            end
        endcase
    end

    // column after the run; a run cut under an older, wider row can wrap
    // more than once, the remainder is then folded down a width per cycle
    always_comb
    begin
        col_sum = {1'b0, col_eff} + {11'd0, push_cmd.count};
        if (({1'b0, col_eff} + 17'd1) >= {1'b0, image_width})
            col_wrap = {11'd0, push_cmd.count} - 17'd1;
        else
            col_wrap = col_sum - {1'b0, image_width};

        fix_next = 1'b0;
        if (fix_reg)
        begin
            if (image_width <= 16'd1)
                col_next = 16'd0;
            else if (col_reg >= image_width)
            begin
                col_next = col_reg - image_width;
                fix_next = 1'b1;
            end
            else
                col_next = col_reg;
        end
        else if (push_cmd.count == 6'd0 || col_sum < {1'b0, image_width})
            col_next = col_sum[15:0];
        else
        begin
            col_next = col_wrap[15:0];
            fix_next = (col_wrap >= {1'b0, image_width});
        end
    end

    assign push = take && ((push_cmd.count != 6'd0) || start_image);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CMD;
            pend_reg <= 6'd0;
            col_reg  <= 16'd0;
            fix_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg <= mode_next;
                pend_reg <= pend_next;
            end
            if (take || fix_reg)
            begin
                col_reg <= col_next;
                fix_reg <= fix_next;
            end
        end
    end

endmodule

// ----- rtl/prbd_queue.sv -----
`timescale 1ns / 1ps
module prbd_queue
    import prbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  run_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output run_cmd_t head
);

    run_cmd_t         mem_reg [QDepth];
    logic [QPtrW-1:0] wr_reg, wr_next;
    logic [QPtrW-1:0] rd_reg, rd_next;
    logic [QPtrW:0]   fill_reg, fill_next;

    assign full  = (fill_reg == (QPtrW + 1)'(QDepth));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- rtl/prbd_back.sv -----
`timescale 1ns / 1ps
module prbd_back
    import prbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] image_width,
    input  logic [15:0] image_height,
    input  logic        q_empty,
    input  run_cmd_t    head,
    output logic        pop,
    output logic        pix_valid,
    input  logic        pix_ready,
    output logic [1:0]  pixel_kind,
    output logic [7:0]  color_index,
    output logic [7:0]  player_shade,
    output logic [15:0] column,
    output logic [15:0] row,
    output logic        row_done,
    output logic        image_done,
    output logic        run_last
);

    logic [5:0]   cnt_reg;
    pixel_kind_t  kind_reg;
    logic [7:0]   color_reg, shade_reg;
    logic [15:0]  col_reg, row_reg;
    logic         valid_reg;
    logic         emit;
    logic         rdone, idone;

    logic [1:0]   o_kind_reg;
    logic [7:0]   o_color_reg, o_shade_reg;
    logic [15:0]  o_col_reg, o_row_reg;
    logic         o_rdone_reg, o_idone_reg, o_last_reg;

    assign pop   = (cnt_reg == 6'd0) && !q_empty;
    assign emit  = (cnt_reg != 6'd0) && (!valid_reg || pix_ready);
    assign rdone = ({1'b0, col_reg} + 17'd1) >= {1'b0, image_width};
    assign idone = rdone && (({1'b0, row_reg} + 17'd1) >= {1'b0, image_height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 6'd0;
            col_reg   <= 16'd0;
            row_reg   <= 16'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cnt_reg <= head.count;
                if (head.restart)
                begin
                    col_reg <= 16'd0;
                    row_reg <= 16'd0;
                end
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (rdone)
                begin
                    col_reg <= 16'd0;
                    row_reg <= idone ? 16'd0 : row_reg + 16'd1;
                end
                else
                    col_reg <= col_reg + 16'd1;
            end

            if (emit)
                valid_reg <= 1'b1;
            else if (pix_ready)
                valid_reg <= 1'b0;
        end
    end

    // run payload and output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= head.kind;
            color_reg <= head.color;
            shade_reg <= head.shade;
        end
        if (emit)
        begin
            o_kind_reg  <= kind_reg;
            o_color_reg <= color_reg;
            o_shade_reg <= shade_reg;
            o_col_reg   <= col_reg;
            o_row_reg   <= row_reg;
            o_rdone_reg <= rdone;
            o_idone_reg <= idone;
            o_last_reg  <= (cnt_reg == 6'd1);
        end
    end

    assign pix_valid    = valid_reg;
    assign pixel_kind   = o_kind_reg;
    assign color_index  = o_color_reg;
    assign player_shade = o_shade_reg;
    assign column       = o_col_reg;
    assign row          = o_row_reg;
    assign row_done     = o_rdone_reg;
    assign image_done   = o_idone_reg;
    assign run_last     = o_last_reg;

endmodule

// ----- rtl/player_bitmap_rle_decoder.sv -----
`timescale 1ns / 1ps
// Path: runs pass the run queue, the back's run register and the output register.
// Throughput: one byte a cycle while the 4-entry run queue has room; a run that wraps
// a row more than once after a width change stalls input until the column is folded.
// Output: one pixel a cycle within a run while m_tready allows; each run loads first.
// Reset (rst_n, async, active low): queue empty, column/row 0, command mode,
// width and height back to 64.
module player_bitmap_rle_decoder
    import prbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // compressed byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_image
    // decoded pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] color_index, [15:8] player_shade,
                                   // [31:16] column, [47:32] row
    output logic [3:0]  m_tuser,   // [1:0] pixel_kind, [2] image_done, [3] run_last
    output logic        m_tlast    // row_done
);

    localparam logic [7:0] RegWidth  = 8'd0;
    localparam logic [7:0] RegHeight = 8'd1;

    logic [15:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd64;
            height_reg <= 16'd64;
        end
        else if (cfg_we)
        begin
            // indexes beyond the list are dropped
            if (cfg_index == RegWidth)
                width_reg <= cfg_data;
            else if (cfg_index == RegHeight)
                height_reg <= cfg_data;
        end
    end

    logic     q_full, q_empty, push, pop;
    run_cmd_t push_cmd, head;

    // front: decodes command and colour bytes into runs (cut to the row end)
    prbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (width_reg),
        .byte_valid  (s_tvalid),
        .data_byte   (s_tdata),
        .start_image (s_tuser),
        .q_full      (q_full),
        .byte_ready  (s_tready),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    prbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    logic [1:0]  pixel_kind;
    logic [7:0]  color_index, player_shade;
    logic [15:0] column, row;
    logic        row_done, image_done, run_last;

    // back: expands each run into pixels, tracks column and row
    prbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_empty      (q_empty),
        .head         (head),
        .pop          (pop),
        .pix_valid    (m_tvalid),
        .pix_ready    (m_tready),
        .pixel_kind   (pixel_kind),
        .color_index  (color_index),
        .player_shade (player_shade),
        .column       (column),
        .row          (row),
        .row_done     (row_done),
        .image_done   (image_done),
        .run_last     (run_last)
    );

    assign m_tdata = {row, column, player_shade, color_index};
    assign m_tuser = {run_last, image_done, pixel_kind};
    assign m_tlast = row_done;

endmodule
